// ===== src/utf8sd_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package utf8sd_pkg;

  // Default number of entries in the queue between classifier and decoder.
  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] CpMin2   = 21'h000080;
  localparam logic [CpW-1:0] CpMin3   = 21'h000800;
  localparam logic [CpW-1:0] CpMin4   = 21'h010000;
  localparam logic [CpW-1:0] SurrLo   = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi   = 21'h00DFFF;
  localparam logic [CpW-1:0] CpMax    = 21'h10FFFF;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_cls_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_LEAD  = 3'd1,
    ERR_BAD_CONT  = 3'd2,
    ERR_OVERLONG  = 3'd3,
    ERR_SURROGATE = 3'd4,
    ERR_RANGE     = 3'd5,
    ERR_TRUNC     = 3'd6
  } err_code_e;

  // Classified byte: class, payload bits already stripped of the tag, end flag.
  typedef struct packed {
    byte_cls_e  cls;
    logic [6:0] data;
    logic       last;
  } byte_item_t;

endpackage

// ===== src/utf8sd_front.sv =====
// Front end: takes input bytes and classifies them into queue items.
module utf8sd_front (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             byte_in_i,
  input  logic                   last_byte_i,
  input  logic                   queue_full_i,
  output logic                   push_o,
  output utf8sd_pkg::byte_item_t push_item_o
);

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    push_item_o.last = last_byte_i;
    case (byte_in_i) inside
      [8'h00:8'h7F]: begin
        push_item_o.cls  = utf8sd_pkg::CLS_ASCII;
        push_item_o.data = byte_in_i[6:0];
      end
      [8'h80:8'hBF]: begin
        push_item_o.cls  = utf8sd_pkg::CLS_CONT;
        push_item_o.data = {1'b0, byte_in_i[5:0]};
      end
      [8'hC0:8'hDF]: begin
        push_item_o.cls  = utf8sd_pkg::CLS_LEAD2;
        push_item_o.data = {2'b0, byte_in_i[4:0]};
      end
      [8'hE0:8'hEF]: begin
        push_item_o.cls  = utf8sd_pkg::CLS_LEAD3;
        push_item_o.data = {3'b0, byte_in_i[3:0]};
      end
      [8'hF0:8'hF7]: begin
        push_item_o.cls  = utf8sd_pkg::CLS_LEAD4;
        push_item_o.data = {4'b0, byte_in_i[2:0]};
      end
      default: begin
        push_item_o.cls  = utf8sd_pkg::CLS_BAD;
        push_item_o.data = '0;
      end
    endcase
  end

endmodule

// ===== src/utf8sd_queue.sv =====
// Small FIFO of classified bytes between front end and decoder.
module utf8sd_queue #(
  parameter int unsigned Depth = utf8sd_pkg::QueueDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  utf8sd_pkg::byte_item_t push_item_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output utf8sd_pkg::byte_item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utf8sd_pkg::byte_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/utf8sd_back.sv =====
// Back end: sequence state, completion checks and the result register.
module utf8sd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  utf8sd_pkg::byte_item_t item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   cp_done_o,
  output logic [20:0]            cp_value_o,
  output logic [2:0]             seq_len_o,
  output logic [2:0]             error_code_o,
  output logic                   end_of_buffer_o,
  output logic                   buffer_ok_o
);

  function automatic utf8sd_pkg::err_code_e check_cp(input logic [2:0]  total,
                                                     input logic [20:0] cp);
    utf8sd_pkg::err_code_e res;
    res = utf8sd_pkg::ERR_NONE;
    if (total == 3'd2) begin
      if (cp < utf8sd_pkg::CpMin2) res = utf8sd_pkg::ERR_OVERLONG;
    end else if (total == 3'd3) begin
      if (cp < utf8sd_pkg::CpMin3) begin
        res = utf8sd_pkg::ERR_OVERLONG;
      end else if (cp >= utf8sd_pkg::SurrLo && cp <= utf8sd_pkg::SurrHi) begin
        res = utf8sd_pkg::ERR_SURROGATE;
      end
    end else begin
      if (cp < utf8sd_pkg::CpMin4) begin
        res = utf8sd_pkg::ERR_OVERLONG;
      end else if (cp > utf8sd_pkg::CpMax) begin
        res = utf8sd_pkg::ERR_RANGE;
      end
    end
    return res;
  endfunction

  logic [1:0]            pending_q, pending_d;
  logic [2:0]            total_q, total_d;
  logic [20:0]           pv_q, pv_d;
  utf8sd_pkg::err_code_e sticky_q, sticky_d;
  logic                  out_valid_q;

  logic [20:0]           pv_shift;
  utf8sd_pkg::err_code_e chk;
  logic                  done;
  logic [20:0]           cp;
  logic [2:0]            width;
  logic                  ok;

  assign pop_o       = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign pv_shift = {pv_q[14:0], item_i.data[5:0]};
  assign chk      = check_cp(total_q, pv_shift);

  always_comb begin
    pending_d = pending_q;
    total_d   = total_q;
    pv_d      = pv_q;
    sticky_d  = sticky_q;
    done      = 1'b0;
    cp        = '0;
    width     = '0;
    if (sticky_q == utf8sd_pkg::ERR_NONE) begin
      if (pending_q == 2'd0) begin
        case (item_i.cls)
          utf8sd_pkg::CLS_ASCII: begin
            done  = 1'b1;
            cp    = {14'b0, item_i.data};
            width = 3'd1;
          end
          utf8sd_pkg::CLS_LEAD2: begin
            pending_d = 2'd1;
            total_d   = 3'd2;
            pv_d      = {14'b0, item_i.data};
          end
          utf8sd_pkg::CLS_LEAD3: begin
            pending_d = 2'd2;
            total_d   = 3'd3;
            pv_d      = {14'b0, item_i.data};
          end
          utf8sd_pkg::CLS_LEAD4: begin
            pending_d = 2'd3;
            total_d   = 3'd4;
            pv_d      = {14'b0, item_i.data};
          end
          default: sticky_d = utf8sd_pkg::ERR_BAD_LEAD;
        endcase
      end else if (item_i.cls != utf8sd_pkg::CLS_CONT) begin
        sticky_d = utf8sd_pkg::ERR_BAD_CONT;
      end else begin
        pv_d      = pv_shift;
        pending_d = pending_q - 2'd1;
        if (pending_q == 2'd1) begin
          if (chk != utf8sd_pkg::ERR_NONE) begin
            sticky_d = chk;
          end else begin
            done  = 1'b1;
            cp    = pv_shift;
            width = total_q;
          end
          pv_d    = '0;
          total_d = '0;
        end
      end
    end
    // sequence cut off by the end of the buffer
    if (item_i.last && sticky_d == utf8sd_pkg::ERR_NONE && pending_d != 2'd0) begin
      sticky_d = utf8sd_pkg::ERR_TRUNC;
    end
    ok = item_i.last && (sticky_d == utf8sd_pkg::ERR_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      total_q     <= '0;
      pv_q        <= '0;
      sticky_q    <= utf8sd_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        if (item_i.last) begin
          pending_q <= '0;
          total_q   <= '0;
          pv_q      <= '0;
          sticky_q  <= utf8sd_pkg::ERR_NONE;
        end else begin
          pending_q <= pending_d;
          total_q   <= total_d;
          pv_q      <= pv_d;
          sticky_q  <= sticky_d;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cp_done_o       <= done;
      cp_value_o      <= cp;
      seq_len_o       <= width;
      error_code_o    <= sticky_d;
      end_of_buffer_o <= item_i.last;
      buffer_ok_o     <= ok;
    end
  end

endmodule

// ===== src/utf8_stream_decoder_top.sv =====
// Top level of the strict UTF-8 stream decoder and validator.
//
// Input channel (in_valid_i/in_ready_o): one byte per transfer, byte_in_i
// with last_byte_i set on the final byte of a buffer. Output channel
// (out_valid_o/out_ready_i): exactly one result per input byte, in order.
// A result carries a completed code point and its width, the sticky error
// of the buffer so far, and on the last byte end_of_buffer_o with the
// buffer_ok_o verdict; decode state then clears for the next buffer.
// A byte taken into the FIFO is registered there, then decoded into the result
// register when the decoder pops it. Throughput: one byte per clock while the
// receiver does not stall, set by the update of the sequence state in the decoder.
// A classifier feeds a QueueDepth-entry FIFO, which the decoder drains into
// its result register. When the receiver stalls, the result register holds
// and the FIFO absorbs new bytes; in_ready_o drops once the FIFO is full.
// Reset clears the FIFO, decode state and out_valid_o; no clearing pass.
module utf8_stream_decoder_top #(
  parameter int unsigned QueueDepth = utf8sd_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        cp_done_o,
  output logic [20:0] cp_value_o,
  output logic [2:0]  seq_len_o,
  output logic [2:0]  error_code_o,
  output logic        end_of_buffer_o,
  output logic        buffer_ok_o
);

  logic                   push;
  utf8sd_pkg::byte_item_t push_item;
  logic                   queue_full;
  logic                   pop;
  logic                   queue_valid;
  utf8sd_pkg::byte_item_t queue_item;

  utf8sd_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_in_i    (byte_in_i),
    .last_byte_i  (last_byte_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  utf8sd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .item_o      (queue_item)
  );

  utf8sd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (queue_valid),
    .item_i          (queue_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cp_done_o       (cp_done_o),
    .cp_value_o      (cp_value_o),
    .seq_len_o       (seq_len_o),
    .error_code_o    (error_code_o),
    .end_of_buffer_o (end_of_buffer_o),
    .buffer_ok_o     (buffer_ok_o)
  );

`ifndef SYNTHESIS
  a_ok_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && buffer_ok_o |->
      end_of_buffer_o && (error_code_o == utf8sd_pkg::ERR_NONE))
    else $error("buffer_ok without end of buffer or with an error");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cp_done_o |->
      (error_code_o == utf8sd_pkg::ERR_NONE) && (seq_len_o != 3'd0) &&
      (cp_value_o <= utf8sd_pkg::CpMax))
    else $error("completed code point with error, zero width or out of range");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cp_done_o |-> (seq_len_o == 3'd0) && (cp_value_o == '0))
    else $error("code point fields set without a completed code point");

  a_end_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_buffer_o && !buffer_ok_o |->
      (error_code_o != utf8sd_pkg::ERR_NONE))
    else $error("failed buffer reported without an error code");
`endif

endmodule
